/* sv/cre_pkg.sv */
package cre_pkg;

  localparam int KEY_W    = 64;
  localparam int KEY_REGS = 6;
  localparam int CFG_IW   = 3;

  localparam logic [1:0] CMD_FEED  = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_COMMA = 8'h2c;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef enum logic [2:0] {
    OP_CHAR,
    OP_COMMA,
    OP_EOL,
    OP_END,
    OP_READ,
    OP_CLEAR,
    OP_NOP
  } op_kind_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] text_byte;
    logic [8:0] read_index;
  } in_t;

  typedef struct packed {
    logic       matched;
    logic       end_of_data;
    logic [8:0] code_count;
    logic [9:0] code_value;
  } out_t;

  typedef struct packed {
    op_kind_t   kind;
    logic [7:0] ch;
    logic [8:0] idx;
  } op_t;

endpackage

/* sv/cre_front.sv */
module cre_front
  import cre_pkg::*;
(
  input  in_t in_data,
  output op_t op
);

  always_comb begin
    op.ch  = in_data.text_byte;
    op.idx = in_data.read_index;
    unique case (in_data.cmd)
      CMD_FEED: begin
        if (in_data.text_byte == 8'd0) begin
          op.kind = OP_END;
        end else if (in_data.text_byte == CH_CR || in_data.text_byte == CH_LF) begin
          op.kind = OP_EOL;
        end else if (in_data.text_byte == CH_COMMA) begin
          op.kind = OP_COMMA;
        end else begin
          op.kind = OP_CHAR;
        end
      end
      CMD_READ:  op.kind = OP_READ;
      CMD_CLEAR: op.kind = OP_CLEAR;
      default:   op.kind = OP_NOP;
    endcase
  end

endmodule

/* sv/cre_queue.sv */
module cre_queue
  import cre_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  op_t  push_op,
  output logic full,
  input  logic pop,
  output logic q_valid,
  output op_t  q_op
);

  op_t        ent_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign full    = (cnt_r == 2'd2);
  assign q_valid = (cnt_r != 2'd0);
  assign q_op    = ent_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ pop;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_op;
    end
  end

endmodule

/* sv/cre_back.sv */
module cre_back
  import cre_pkg::*;
#(
  parameter int MAX_CODES   = 511,
  parameter int FIELD_CHARS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  op_t               q_op,
  output logic              pop,
  input  logic              cfg_we,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [KEY_W-1:0]  cfg_wdata,
  output logic              out_valid,
  input  logic              out_stall,
  output out_t              out_data
);

  localparam int AW = (MAX_CODES > 1) ? $clog2(MAX_CODES) : 1;
  localparam int CW = $clog2(MAX_CODES + 1);
  localparam int XW = (CW > 9) ? CW : 9;
  localparam int FC = FIELD_CHARS;

  logic [KEY_W-1:0] key_r [KEY_REGS];

  logic [7:0]    fi_r, fi_nxt;
  logic [4:0]    cc_r, cc_nxt;
  logic          skip_r, skip_nxt;
  logic [7:0]    text_r [3][FC+1];
  logic [7:0]    text_nxt [3][FC+1];
  logic [7:0]    dig_r [3];
  logic [7:0]    dig_nxt [3];
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          found_r, found_nxt;

  logic [9:0]    mem [MAX_CODES];
  logic [9:0]    rdata_r;
  logic          wr_en;
  logic [9:0]    dval;

  logic          out_valid_r;
  logic          matched_r, eod_r, rd_ok_r;
  logic [8:0]    count_r;
  logic          eod_nxt, rd_ok;

  logic [XW-1:0] idx_x, cnt_x;
  logic [2:0]    fmatch;
  logic [4:0]    k;
  logic [1:0]    fsel;

  assign pop       = q_valid && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;
  assign idx_x     = XW'(q_op.idx);
  assign cnt_x     = XW'(cnt_r);
  assign rd_ok     = (q_op.kind == OP_READ) && (idx_x < cnt_x)
                     && (idx_x < XW'(MAX_CODES));

  always_comb begin
    logic run;
    logic [7:0] kb;
    for (int w = 0; w < 3; w++) begin
      run = 1'b1;
      fmatch[w] = 1'b0;
      for (int i = 0; i <= FC; i++) begin
        kb = (i < 16) ? key_r[w * 2 + i / 8][(i % 8) * 8 +: 8] : 8'd0;
        if (run && text_r[w][i] == kb && kb == 8'd0) begin
          fmatch[w] = 1'b1;
        end
        run = run && (text_r[w][i] == kb);
      end
    end
  end

  always_comb begin
    logic go;
    dval = 10'd0;
    go   = 1'b1;
    for (int i = 0; i < 3; i++) begin
      go = go && (dig_r[i] >= CH_ZERO) && (dig_r[i] <= CH_NINE);
      if (go) begin
        dval = 10'(dval * 10'd10 + 10'(dig_r[i] - CH_ZERO));
      end
    end
  end

  always_comb begin
    fi_nxt    = fi_r;
    cc_nxt    = cc_r;
    skip_nxt  = skip_r;
    text_nxt  = text_r;
    dig_nxt   = dig_r;
    cnt_nxt   = cnt_r;
    found_nxt = found_r;
    eod_nxt   = 1'b0;
    wr_en     = 1'b0;
    k         = 5'd0;
    fsel      = fi_r[1:0];
    if (q_op.kind == OP_CLEAR) begin
      fi_nxt    = 8'd0;
      cc_nxt    = 5'd0;
      skip_nxt  = 1'b0;
      cnt_nxt   = '0;
      found_nxt = 1'b0;
      for (int w = 0; w < 3; w++) begin
        for (int i = 0; i <= FC; i++) begin
          text_nxt[w][i] = 8'd0;
        end
      end
      for (int i = 0; i < 3; i++) begin
        dig_nxt[i] = 8'd0;
      end
    end else if (q_op.kind == OP_CHAR || q_op.kind == OP_COMMA
                 || q_op.kind == OP_EOL || q_op.kind == OP_END) begin
      if (found_r) begin
      end else if (skip_r) begin
        skip_nxt = 1'b0;
      end else if (q_op.kind == OP_END) begin
        eod_nxt = 1'b1;
      end else if (q_op.kind == OP_EOL) begin
        if (&fmatch) begin
          found_nxt = 1'b1;
        end else begin
          cnt_nxt  = '0;
          fi_nxt   = 8'd0;
          cc_nxt   = 5'd0;
          skip_nxt = 1'b1;
        end
      end else if (q_op.kind == OP_COMMA) begin
        if (fi_r > 8'd2 && cnt_x < XW'(MAX_CODES)) begin
          wr_en   = 1'b1;
          cnt_nxt = CW'(cnt_r + 1'b1);
        end
        if (fi_r != 8'd255) begin
          fi_nxt = fi_r + 8'd1;
        end
        cc_nxt = 5'd0;
      end else if (fi_r < 8'd3) begin
        k = (cc_r > 5'(FC)) ? 5'(FC) : cc_r;
        for (int i = 0; i <= FC; i++) begin
          if (5'(i) == k) begin
            text_nxt[fsel][i] = q_op.ch;
          end
          if (k < 5'(FC) && 5'(i) == k + 5'd1) begin
            text_nxt[fsel][i] = 8'd0;
          end
        end
        cc_nxt = (k < 5'(FC)) ? k + 5'd1 : k;
      end else begin
        k = (cc_r > 5'd2) ? 5'd2 : cc_r;
        for (int i = 0; i < 3; i++) begin
          if (5'(i) == k) begin
            dig_nxt[i] = q_op.ch;
          end
          if (k < 5'd2 && 5'(i) == k + 5'd1) begin
            dig_nxt[i] = 8'd0;
          end
        end
        cc_nxt = (k < 5'd2) ? k + 5'd1 : k;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < KEY_REGS; i++) begin
        key_r[i] <= '0;
      end
    end else if (cfg_we && cfg_index < CFG_IW'(KEY_REGS)) begin
      key_r[cfg_index] <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fi_r        <= 8'd0;
      cc_r        <= 5'd0;
      skip_r      <= 1'b0;
      cnt_r       <= '0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
      for (int w = 0; w < 3; w++) begin
        for (int i = 0; i <= FC; i++) begin
          text_r[w][i] <= 8'd0;
        end
      end
      for (int i = 0; i < 3; i++) begin
        dig_r[i] <= 8'd0;
      end
    end else begin
      if (pop) begin
        fi_r    <= fi_nxt;
        cc_r    <= cc_nxt;
        skip_r  <= skip_nxt;
        cnt_r   <= cnt_nxt;
        found_r <= found_nxt;
        text_r  <= text_nxt;
        dig_r   <= dig_nxt;
      end
      if (pop) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && wr_en) begin
      mem[cnt_r[AW-1:0]] <= dval;
    end
    if (pop) begin
      rdata_r   <= mem[idx_x[AW-1:0]];
      rd_ok_r   <= rd_ok;
      matched_r <= found_nxt;
      eod_r     <= eod_nxt;
      count_r   <= 9'(cnt_nxt);
    end
  end

  always_comb begin
    out_data.matched     = matched_r;
    out_data.end_of_data = eod_r;
    out_data.code_count  = count_r;
    out_data.code_value  = rd_ok_r ? rdata_r : 10'd0;
  end

endmodule

/* sv/csv_record_code_extractor.sv */
// CSV record code extractor.
// Input channel (in_valid/in_stall/in_data): one command per transaction:
// feed a text byte, read a stored code by index, clear the parser, or no-op.
// Every accepted transaction gives exactly one result transaction on
// out_valid/out_stall/out_data carrying matched, end_of_data, code_count
// and, for reads, the stored code.
// Keys are written through cfg_we/cfg_index/cfg_wdata, one 64-bit register
// per write; the user must write only while no transaction is in flight,
// which the block itself does not enforce. Throughput: one transaction per
// cycle while the output is not stalled. A transaction passes the two-entry
// queue, then the parser, whose output register also holds the code memory's
// registered read data. A stalled receiver holds the output register; the
// queue absorbs up to two more transactions before in_stall rises.
// Reset clears parser state, keys, queue and output valid; the code memory
// is not cleared and is read only below the stored count.
module csv_record_code_extractor
  import cre_pkg::*;
#(
  parameter int MAX_CODES   = 511,
  parameter int FIELD_CHARS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_t               in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output out_t              out_data,
  input  logic              cfg_we,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [KEY_W-1:0]  cfg_wdata
);

  op_t  front_op, q_op;
  logic full, q_valid, pop;

  assign in_stall = full;

  cre_front u_front (
    .in_data (in_data),
    .op      (front_op)
  );

  cre_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (in_valid && !full),
    .push_op (front_op),
    .full    (full),
    .pop     (pop),
    .q_valid (q_valid),
    .q_op    (q_op)
  );

  cre_back #(
    .MAX_CODES   (MAX_CODES),
    .FIELD_CHARS (FIELD_CHARS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_op      (q_op),
    .pop       (pop),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

/* test/tb.sv */
module tb;
  import cre_pkg::*;

  localparam int NCODES = 511;
  localparam int NCHARS = 16;
  localparam int REG_TYPE_LO = 0;
  localparam int REG_TYPE_HI = 1;
  localparam int REG_NAME_LO = 2;
  localparam int REG_FUNC_LO = 4;
  localparam logic [1:0] CMD_NOP = 2'd3;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_t in_data;
  logic out_valid;
  logic out_stall;
  out_t out_data;
  logic cfg_we;
  logic [CFG_IW-1:0] cfg_index;
  logic [KEY_W-1:0] cfg_wdata;

  csv_record_code_extractor uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // parser model state
  logic [63:0] keys [KEY_REGS];
  int fld;
  int nch;
  bit skip;
  logic [7:0] txt [3][17];
  logic [7:0] dig [3];
  logic [9:0] codes [NCODES];
  int ncodes;
  bit hit;

  out_t pending [$];
  int errors = 0;
  int items_sent = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_recv = 0;

  function automatic logic [7:0] key_char(int w, int i);
    logic [63:0] r;
    r = keys[w * 2 + i / 8];
    return r[(i % 8) * 8 +: 8];
  endfunction

  function automatic bit text_equal(int w);
    logic [7:0] k;
    for (int i = 0; i <= NCHARS; i++) begin
      k = (i < NCHARS) ? key_char(w, i) : 8'h00;
      if (txt[w][i] != k) return 0;
      if (txt[w][i] == 8'h00) return 1;
    end
    return 0;
  endfunction

  function automatic logic [9:0] code_of_digits();
    int v;
    v = 0;
    for (int i = 0; i < 3; i++) begin
      if (dig[i] < CH_ZERO || dig[i] > CH_NINE) break;
      v = v * 10 + (dig[i] - CH_ZERO);
    end
    return 10'(v);
  endfunction

  function automatic void parser_clear();
    fld = 0; nch = 0; skip = 0; ncodes = 0; hit = 0;
    for (int w = 0; w < 3; w++) for (int i = 0; i < 17; i++) txt[w][i] = 0;
    for (int i = 0; i < 3; i++) dig[i] = 0;
  endfunction

  function automatic bit feed_char(logic [7:0] c);
    int k;
    if (hit) return 0;
    if (skip) begin
      skip = 0;
      return 0;
    end
    if (c == 8'h00) return 1;
    if (c == CH_CR || c == CH_LF) begin
      if (text_equal(1) && text_equal(0) && text_equal(2)) begin
        hit = 1;
        return 0;
      end
      ncodes = 0; fld = 0; nch = 0; skip = 1;
    end else if (c == CH_COMMA) begin
      if (fld > 2 && ncodes < NCODES) begin
        codes[ncodes] = code_of_digits();
        ncodes++;
      end
      if (fld < 255) fld++;
      nch = 0;
    end else if (fld <= 2) begin
      k = (nch > NCHARS) ? NCHARS : nch;
      txt[fld][k] = c;
      if (k < NCHARS) begin
        k++;
        txt[fld][k] = 0;
      end
      nch = k;
    end else begin
      k = (nch > 2) ? 2 : nch;
      dig[k] = c;
      if (k < 2) begin
        k++;
        dig[k] = 0;
      end
      nch = k;
    end
    return 0;
  endfunction

  function automatic out_t predict_result(in_t t);
    out_t r;
    r = '0;
    case (t.cmd)
      CMD_FEED: r.end_of_data = feed_char(t.text_byte);
      CMD_READ: if (t.read_index < ncodes) r.code_value = codes[t.read_index];
      CMD_CLEAR: parser_clear();
      default: ;
    endcase
    r.matched = hit;
    r.code_count = 9'(ncodes);
    return r;
  endfunction

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50000000;
    $display("Mismatches found");
    $finish;
  end

  // receiver
  always @(posedge clk) begin
    out_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pending.size() == 0) begin
        $error("result with nothing expected");
        errors++;
      end else begin
        e = pending.pop_front();
        if (out_data.matched != e.matched) begin
          $error("matched exp %0d got %0d", e.matched, out_data.matched); errors++;
        end
        if (out_data.end_of_data != e.end_of_data) begin
          $error("end_of_data exp %0d got %0d", e.end_of_data, out_data.end_of_data);
          errors++;
        end
        if (out_data.code_count != e.code_count) begin
          $error("code_count exp %0d got %0d", e.code_count, out_data.code_count);
          errors++;
        end
        if (out_data.code_value != e.code_value) begin
          $error("code_value exp %0d got %0d", e.code_value, out_data.code_value);
          errors++;
        end
      end
    end
    out_stall <= hold_recv || ($urandom_range(99) < recv_idle_pct);
  end

  // in_valid stays high after an accept so back-to-back sends need no gap
  task automatic send(in_t t);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_data <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending.push_back(predict_result(t));
    items_sent++;
  endtask

  task automatic send_checked(in_t t, out_t want);
    out_t p;
    send(t);
    p = pending[$];
    if (p != want) begin
      $error("predictor row exp %h got %h", want, p);
      errors++;
    end
  endtask

  task automatic drain();
    in_valid <= 0;
    while (pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_key(int idx, logic [63:0] v);
    cfg_we <= 1;
    cfg_index <= CFG_IW'(idx);
    cfg_wdata <= v;
    keys[idx] = v;
    @(posedge clk);
    cfg_we <= 0;
  endtask

  function automatic in_t mk(logic [1:0] c, logic [7:0] b, logic [8:0] i);
    in_t t;
    t.cmd = c; t.text_byte = b; t.read_index = i;
    return t;
  endfunction

  task automatic send_str(string s);
    for (int i = 0; i < s.len(); i++) send(mk(CMD_FEED, s[i], 9'($urandom)));
  endtask

  // 16-byte key split over two registers
  task automatic set_pair(int lo, string s);
    logic [127:0] v;
    v = '0;
    for (int i = 0; i < s.len() && i < 16; i++) v[i * 8 +: 8] = s[i];
    set_key(lo, v[63:0]);
    set_key(lo + 1, v[127:64]);
  endtask

  function automatic string rand_word(int maxlen);
    string s;
    int n;
    s = "";
    n = $urandom_range(maxlen);
    for (int i = 0; i < n; i++) s = {s, string'(8'($urandom_range(8'h61, 8'h7a)))};
    return s;
  endfunction

  // well-formed line with random codes, some odd
  task automatic send_line(string ty, string nm, string fn, int ncode);
    string s;
    s = {ty, ",", nm, ",", fn};
    for (int i = 0; i < ncode; i++) begin
      s = {s, ","};
      case ($urandom_range(9))
        0: s = {s, ""};
        1: s = {s, "12345"};
        2: s = {s, "7x"};
        default: s = {s, $sformatf("%0d", $urandom_range(999))};
      endcase
    end
    if ($urandom_range(1)) s = {s, ","};
    s = {s, $urandom_range(1) ? "\r" : "\n", "\n"};
    send_str(s);
  endtask

  typedef struct {
    in_t stim;
    bit has_exp;
    out_t exp;
  } row_t;

  initial begin
    row_t rows [$];
    out_t o;
    string tys [3];
    string nms [3];
    string fns [3];
    int n;
    rst_n = 0;
    in_valid = 0;
    in_data = '0;
    out_stall = 0;
    cfg_we = 0;
    cfg_index = '0;
    cfg_wdata = '0;
    for (int i = 0; i < KEY_REGS; i++) keys[i] = '0;
    parser_clear();
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: all-zero keys match empty fields at once
    o = '0;
    rows.push_back('{mk(CMD_READ, 8'hff, 9'd0), 1, o});
    rows.push_back('{mk(CMD_NOP, 8'h00, 9'h1ff), 1, o});
    o.end_of_data = 1;
    rows.push_back('{mk(CMD_FEED, 8'h00, 9'd0), 1, o});
    o = '0; o.matched = 1;
    rows.push_back('{mk(CMD_FEED, CH_LF, 9'd0), 1, o});
    rows.push_back('{mk(CMD_FEED, 8'h00, 9'd0), 1, o});
    o = '0;
    rows.push_back('{mk(CMD_CLEAR, 8'hff, 9'h1ff), 1, o});
    foreach (rows[i]) begin
      if (rows[i].has_exp) send_checked(rows[i].stim, rows[i].exp);
      else send(rows[i].stim);
    end
    drain();

    set_pair(REG_TYPE_LO, "abcdefghijklmnop");
    set_pair(REG_NAME_LO, "dev");
    set_pair(REG_FUNC_LO, "f");
    // overlong, skip-after-eol zero, field 255 saturation, bad codes, reads
    send_str("abcdefghijklmnopq,dev,f,1,2\r\n");
    send_str("x\n");
    send(mk(CMD_FEED, 8'h00, 0));
    send(mk(CMD_FEED, 8'hff, 0));
    send(mk(CMD_FEED, 8'h80, 0));
    send_str(",,,999,0,,9999,a,");
    for (int i = 0; i < 300; i++) send(mk(CMD_FEED, CH_COMMA, 0));
    for (int i = 0; i < 9; i++) send(mk(CMD_READ, 0, 9'(i)));
    send(mk(CMD_READ, 0, 9'h1ff));
    send(mk(CMD_CLEAR, 0, 0));
    send_line("abcdefghijklmnop", "dev", "f", 3);
    send(mk(CMD_READ, 0, 0));
    send(mk(CMD_READ, 0, 1));
    send(mk(CMD_FEED, 8'h00, 0));
    send(mk(CMD_CLEAR, 0, 0));
    // fill the buffer beyond its limit
    send_str("a,b,c");
    for (int i = 0; i < NCODES + 3; i++) send(mk(CMD_FEED, CH_COMMA, 0));
    send(mk(CMD_READ, 0, 9'd510));
    send(mk(CMD_READ, 0, 9'd511));
    send(mk(CMD_CLEAR, 0, 0));
    drain();
    set_key(REG_TYPE_LO, '1);
    set_key(REG_TYPE_HI, '1);
    send_str(",,\n\n");
    drain();

    // random phases
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 13 : (ph == 1) ? 71 : 0;
      recv_idle_pct = (ph == 0) ? 71 : (ph == 1) ? 13 : 0;
      for (int w = 0; w < 3; w++) begin
        tys[w] = rand_word(w == 2 ? 16 : 5);
        nms[w] = rand_word(5);
        fns[w] = rand_word(4);
      end
      set_pair(REG_TYPE_LO, tys[0]);
      set_pair(REG_NAME_LO, nms[0]);
      set_pair(REG_FUNC_LO, fns[0]);
      send(mk(CMD_CLEAR, 0, 0));
      if (ph == 2) begin
        hold_recv = 1;
        fork
          begin
            repeat (60) @(posedge clk);
            hold_recv = 0;
          end
          for (int i = 0; i < 20; i++) send(mk(CMD_READ, 0, 9'($urandom)));
        join
      end
      n = items_sent;
      while (items_sent - n < 190) begin
        int pick;
        pick = $urandom_range(99);
        if (pick < 70) begin
          int w;
          w = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 2);
          send_line(w == 0 ? tys[0] : tys[w], $urandom_range(2) ? nms[0] : nms[w],
                    $urandom_range(2) ? fns[0] : fns[w], $urandom_range(6));
        end else if (pick < 82) begin
          send(mk(CMD_READ, 0, 9'($urandom_range(ncodes + 2))));
        end else if (pick < 87) begin
          send(mk(CMD_READ, 0, 9'($urandom)));
        end else if (pick < 92) begin
          send(mk(CMD_FEED, 8'($urandom), 9'($urandom)));
        end else if (pick < 95) begin
          send(mk(CMD_FEED, 8'h00, 0));
        end else if (pick < 98) begin
          send(mk(CMD_CLEAR, 8'($urandom), 9'($urandom)));
        end else begin
          send(mk(CMD_NOP, 8'($urandom), 9'($urandom)));
        end
        if (hit && $urandom_range(3) == 0) send(mk(CMD_CLEAR, 0, 0));
        if ($urandom_range(150) == 0) drain();
      end
      drain();
    end

    drain();
    repeat (10) @(posedge clk);
    if (errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end
endmodule
